/* rtl/ptsa_pkg.sv */
// Package: shared types, widths and constants for the pixel-to-angle block.
package ptsa_pkg;

    localparam int COORD_WIDTH   = 12;
    localparam int CORDIC_STAGES = 32;
    localparam int TABLE_LEN     = 40;
    localparam int CORDIC_N      = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    localparam int CENTER_W = 20;
    localparam int PITCH_W  = 24;
    localparam int DIST_W   = 24;
    localparam int ANGLE_W  = 32;

    // datapath width: normalized values stay below 2^51, CORDIC gain adds < 3 bits
    localparam int DW         = 58;
    localparam int NORM_EXP   = 50;
    localparam int NORM_STEPS = 7;
    localparam int DIFF_W     = ((COORD_WIDTH + 8 > CENTER_W) ? COORD_WIDTH + 8 : CENTER_W) + 1;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam int          GAIN_W   = 30;
    localparam logic [29:0] INV_GAIN = 30'd652032874;

    typedef enum logic [2:0] {
        REG_CENTER_COL   = 3'd0,
        REG_CENTER_ROW   = 3'd1,
        REG_PIXEL_WIDTH  = 3'd2,
        REG_PIXEL_HEIGHT = 3'd3,
        REG_DET_DISTANCE = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] col_index;
        logic [COORD_WIDTH-1:0] row_index;
    } in_word_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] theta_angle;
        logic signed [ANGLE_W-1:0] alpha_angle;
    } out_word_t;

    localparam logic signed [ANGLE_W-1:0] ATAN_Q30 [TABLE_LEN] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159, 32'sd67021687,
        32'sd33543516,  32'sd16775851,  32'sd8388437,   32'sd4194283,   32'sd2097149,
        32'sd1048576,   32'sd524288,    32'sd262144,    32'sd131072,    32'sd65536,
        32'sd32768,     32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
        32'sd1024,      32'sd512,       32'sd256,       32'sd128,       32'sd64,
        32'sd32,        32'sd16,        32'sd8,         32'sd4,         32'sd2,
        32'sd1,         32'sd0,         32'sd0,         32'sd0,         32'sd0,
        32'sd0,         32'sd0,         32'sd0,         32'sd0,         32'sd0
    };

    // normalize steps: 32,16,8,4,2,1 while staying below 2^50, then a final x2
    function automatic int norm_shift(input int i);
        return (i < NORM_STEPS - 1) ? (32 >> i) : 1;
    endfunction

    function automatic int norm_exp(input int i);
        return (i < NORM_STEPS - 1) ? (NORM_EXP - (32 >> i)) : NORM_EXP;
    endfunction

endpackage

/* rtl/ptsa_front.sv */
// Front end: centre offset, pixel scaling, magnitude max and normalizing shifts.
module ptsa_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              ce,
    input  logic                              in_valid,
    input  ptsa_pkg::in_word_t                in_word,
    input  logic [ptsa_pkg::CENTER_W-1:0]     center_col,
    input  logic [ptsa_pkg::CENTER_W-1:0]     center_row,
    input  logic [ptsa_pkg::PITCH_W-1:0]      pixel_width,
    input  logic [ptsa_pkg::PITCH_W-1:0]      pixel_height,
    input  logic [ptsa_pkg::DIST_W-1:0]       detector_distance,
    output logic                              out_valid,
    output logic signed [ptsa_pkg::DW-1:0]    out_d,
    output logic signed [ptsa_pkg::DW-1:0]    out_x,
    output logic signed [ptsa_pkg::DW-1:0]    out_y
);
    import ptsa_pkg::*;

    localparam int PROD_W = DIFF_W + PITCH_W + 1;

    // stage 1: offset from centre
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    // stage 2: scale
    logic                     v2_reg;
    logic signed [DW-1:0]     x2_reg, y2_reg, d2_reg;
    logic signed [PROD_W-1:0] px, py;
    logic [DIST_W-1:0]        dist_eff;
    // stage 3: magnitudes
    logic                     v3_reg;
    logic signed [DW-1:0]     x3_reg, y3_reg, d3_reg;
    logic [DW-1:0]            ax3_reg, ay3_reg;
    // normalize chain, index 0 is the max stage
    logic                     nv_reg [NORM_STEPS+1];
    logic signed [DW-1:0]     nx_reg [NORM_STEPS+1];
    logic signed [DW-1:0]     ny_reg [NORM_STEPS+1];
    logic signed [DW-1:0]     nd_reg [NORM_STEPS+1];
    logic [DW-1:0]            nm_reg [NORM_STEPS+1];
    logic [DW-1:0]            m_max;

    assign dist_eff = (detector_distance == '0) ? DIST_W'(1) : detector_distance;
    assign px = dx_reg * $signed({1'b0, pixel_width});
    assign py = dy_reg * $signed({1'b0, pixel_height});

    always_comb begin
        m_max = DW'(unsigned'(d3_reg));
        if (ax3_reg > m_max) begin
            m_max = ax3_reg;
        end
        if (ay3_reg > m_max) begin
            m_max = ay3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            nv_reg[0] <= 1'b0;
        end else if (ce) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            nv_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dx_reg <= $signed(DIFF_W'({in_word.col_index, 8'b0})) - $signed(DIFF_W'(center_col));
            dy_reg <= $signed(DIFF_W'({in_word.row_index, 8'b0})) - $signed(DIFF_W'(center_row));
            x2_reg <= DW'(px);
            y2_reg <= DW'(py);
            d2_reg <= $signed(DW'({dist_eff, 16'b0}));
            x3_reg  <= x2_reg;
            y3_reg  <= y2_reg;
            d3_reg  <= d2_reg;
            ax3_reg <= unsigned'((x2_reg < 0) ? -x2_reg : x2_reg);
            ay3_reg <= unsigned'((y2_reg < 0) ? -y2_reg : y2_reg);
            nx_reg[0] <= x3_reg;
            ny_reg[0] <= y3_reg;
            nd_reg[0] <= d3_reg;
            nm_reg[0] <= m_max;
        end
    end

    for (genvar gi = 0; gi < NORM_STEPS; gi++) begin : g_norm
        localparam int SH = norm_shift(gi);
        localparam int EX = norm_exp(gi);
        logic do_shift;
        assign do_shift = ((nm_reg[gi] >> EX) == '0);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                nv_reg[gi+1] <= 1'b0;
            end else if (ce) begin
                nv_reg[gi+1] <= nv_reg[gi];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                nx_reg[gi+1] <= do_shift ? (nx_reg[gi] <<< SH) : nx_reg[gi];
                ny_reg[gi+1] <= do_shift ? (ny_reg[gi] <<< SH) : ny_reg[gi];
                nd_reg[gi+1] <= do_shift ? (nd_reg[gi] <<< SH) : nd_reg[gi];
                nm_reg[gi+1] <= do_shift ? (nm_reg[gi] << SH) : nm_reg[gi];
            end
        end
    end

    assign out_valid = nv_reg[NORM_STEPS];
    assign out_x     = nx_reg[NORM_STEPS];
    assign out_y     = ny_reg[NORM_STEPS];
    assign out_d     = nd_reg[NORM_STEPS];

endmodule

/* rtl/ptsa_cordic.sv */
// Pipelined vectoring CORDIC, one micro-rotation per stage, with a sideband.
module ptsa_cordic (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                ce,
    input  logic                                in_valid,
    input  logic signed [ptsa_pkg::DW-1:0]      in_a,
    input  logic signed [ptsa_pkg::DW-1:0]      in_b,
    input  logic signed [ptsa_pkg::DW-1:0]      in_side,
    output logic                                out_valid,
    output logic signed [ptsa_pkg::DW-1:0]      out_mag,
    output logic signed [ptsa_pkg::ANGLE_W-1:0] out_z,
    output logic signed [ptsa_pkg::DW-1:0]      out_side
);
    import ptsa_pkg::*;

    logic                      v_reg    [CORDIC_N];
    logic signed [DW-1:0]      a_reg    [CORDIC_N];
    logic signed [DW-1:0]      b_reg    [CORDIC_N];
    logic signed [ANGLE_W-1:0] z_reg    [CORDIC_N];
    logic signed [DW-1:0]      side_reg [CORDIC_N];

    for (genvar gi = 0; gi < CORDIC_N; gi++) begin : g_stage
        logic                      v_in;
        logic signed [DW-1:0]      a_in, b_in, s_in, sa, sb;
        logic signed [ANGLE_W-1:0] z_in;

        if (gi == 0) begin : g_first
            assign v_in = in_valid;
            assign a_in = in_a;
            assign b_in = in_b;
            assign z_in = '0;
            assign s_in = in_side;
        end else begin : g_next
            assign v_in = v_reg[gi-1];
            assign a_in = a_reg[gi-1];
            assign b_in = b_reg[gi-1];
            assign z_in = z_reg[gi-1];
            assign s_in = side_reg[gi-1];
        end

        // arithmetic shift floors toward minus infinity
        assign sa = a_in >>> gi;
        assign sb = b_in >>> gi;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[gi] <= 1'b0;
            end else if (ce) begin
                v_reg[gi] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                side_reg[gi] <= s_in;
                if (b_in >= 0) begin
                    a_reg[gi] <= a_in + sb;
                    b_reg[gi] <= b_in - sa;
                    z_reg[gi] <= z_in + ATAN_Q30[gi];
                end else begin
                    a_reg[gi] <= a_in - sb;
                    b_reg[gi] <= b_in + sa;
                    z_reg[gi] <= z_in - ATAN_Q30[gi];
                end
            end
        end
    end

    assign out_valid = v_reg[CORDIC_N-1];
    assign out_mag   = a_reg[CORDIC_N-1];
    assign out_z     = z_reg[CORDIC_N-1];
    assign out_side  = side_reg[CORDIC_N-1];

endmodule

/* rtl/ptsa_gain.sv */
// Gain correction: multiplies the CORDIC magnitude by 1/K in split partial products.
module ptsa_gain (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                ce,
    input  logic                                in_valid,
    input  logic signed [ptsa_pkg::DW-1:0]      in_mag,
    input  logic signed [ptsa_pkg::DW-1:0]      in_y,
    input  logic signed [ptsa_pkg::ANGLE_W-1:0] in_theta,
    output logic                                out_valid,
    output logic signed [ptsa_pkg::DW-1:0]      out_lp,
    output logic signed [ptsa_pkg::DW-1:0]      out_y,
    output logic signed [ptsa_pkg::ANGLE_W-1:0] out_theta
);
    import ptsa_pkg::*;

    localparam int LO_W  = 20;
    localparam int HI_W  = DW - LO_W;
    localparam int HL_W  = 17;
    localparam int HH_W  = HI_W - HL_W;
    localparam int SUM_W = HI_W + GAIN_W + 1;

    logic [HI_W-1:0]          hi;
    logic                     v1_reg, v2_reg;
    logic [HH_W+GAIN_W-1:0]   ph_reg;
    logic [HL_W+GAIN_W-1:0]   pl_reg;
    logic [LO_W+GAIN_W-1:0]   plo_reg;
    logic signed [DW-1:0]     y1_reg, y2_reg;
    logic signed [ANGLE_W-1:0] t1_reg, t2_reg;
    logic signed [DW-1:0]     lp_reg;
    logic [SUM_W-1:0]         hi_prod, total;

    assign hi = in_mag[DW-1:LO_W];
    assign hi_prod = (SUM_W'(ph_reg) << HL_W) + SUM_W'(pl_reg);
    assign total   = (hi_prod >> 10) + SUM_W'(plo_reg >> GAIN_W);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ph_reg  <= hi[HI_W-1:HL_W] * INV_GAIN;
            pl_reg  <= hi[HL_W-1:0] * INV_GAIN;
            plo_reg <= in_mag[LO_W-1:0] * INV_GAIN;
            y1_reg  <= in_y;
            t1_reg  <= in_theta;
            lp_reg  <= $signed(total[DW-1:0]);
            y2_reg  <= y1_reg;
            t2_reg  <= t1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_lp    = lp_reg;
    assign out_y     = y2_reg;
    assign out_theta = t2_reg;

endmodule

/* rtl/pixel_to_scattering_angles.sv */
// Top level: flat-detector pixel to scattering angle pipeline with APB setup port.
//
// Usage: the s_ channel takes one word per pixel (column, row); the m_ channel
// returns one word per pixel with theta = atan(x/d) and alpha = atan(y/l),
// both signed radians with 30 fraction bits, in input order.
// Setup registers (centre, pixel pitch, distance) sit on the APB port at
// byte address 4*i; change them only while no pixel is in flight.
// Throughput: one word per cycle, fully pipelined, while the skid is empty.
// Pipeline: 11 front stages (offset, scale, abs, max, 7 normalize steps),
// 32 CORDIC stages for theta, 2 gain stages, 32 CORDIC stages for alpha and
// the output register, from accept to m_valid.
// Stall: the whole pipeline holds on one clock enable. A two-entry output
// (output register plus skid) lets a finished word wait for m_ready while
// the pipeline keeps moving; s_ready drops only when the skid is full.
// Reset (aresetn low, synchronous): valid bits clear, setup registers
// return to their defaults; no clearing pass is needed.
module pixel_to_scattering_angles (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ptsa_pkg::in_word_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ptsa_pkg::out_word_t          m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptsa_pkg::PADDR_W-1:0] paddr,
    input  logic [ptsa_pkg::PDATA_W-1:0] pwdata,
    output logic [ptsa_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import ptsa_pkg::*;

    // setup registers
    logic [CENTER_W-1:0] center_col_reg, center_row_reg;
    logic [PITCH_W-1:0]  pixel_width_reg, pixel_height_reg;
    logic [DIST_W-1:0]   distance_reg;
    reg_index_t          reg_sel;

    // pipeline enable: hold everything once the skid holds a word
    logic ce;

    logic                      f_valid;
    logic signed [DW-1:0]      f_d, f_x, f_y;
    logic                      c1_valid;
    logic signed [DW-1:0]      c1_mag, c1_y;
    logic signed [ANGLE_W-1:0] c1_theta;
    logic                      g_valid;
    logic signed [DW-1:0]      g_lp, g_y;
    logic signed [ANGLE_W-1:0] g_theta;
    logic                      c2_valid;
    logic signed [DW-1:0]      c2_mag, c2_side;
    logic signed [ANGLE_W-1:0] c2_alpha;

    // output register and skid
    logic      out_valid_reg, skid_valid_reg;
    out_word_t out_word_reg, skid_word_reg;
    out_word_t new_word;
    logic      new_valid;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_col_reg   <= CENTER_W'(524288);
            center_row_reg   <= CENTER_W'(524288);
            pixel_width_reg  <= PITCH_W'(44032);
            pixel_height_reg <= PITCH_W'(44032);
            distance_reg     <= DIST_W'(1000000);
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_CENTER_COL:   center_col_reg   <= pwdata[CENTER_W-1:0];
                REG_CENTER_ROW:   center_row_reg   <= pwdata[CENTER_W-1:0];
                REG_PIXEL_WIDTH:  pixel_width_reg  <= pwdata[PITCH_W-1:0];
                REG_PIXEL_HEIGHT: pixel_height_reg <= pwdata[PITCH_W-1:0];
                REG_DET_DISTANCE: distance_reg     <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_CENTER_COL:   prdata = PDATA_W'(center_col_reg);
            REG_CENTER_ROW:   prdata = PDATA_W'(center_row_reg);
            REG_PIXEL_WIDTH:  prdata = PDATA_W'(pixel_width_reg);
            REG_PIXEL_HEIGHT: prdata = PDATA_W'(pixel_height_reg);
            REG_DET_DISTANCE: prdata = PDATA_W'(distance_reg);
            default:          prdata = '0;
        endcase
    end

    assign ce      = !skid_valid_reg;
    assign s_ready = ce;

    ptsa_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ce                (ce),
        .in_valid          (s_valid),
        .in_word           (s_data),
        .center_col        (center_col_reg),
        .center_row        (center_row_reg),
        .pixel_width       (pixel_width_reg),
        .pixel_height      (pixel_height_reg),
        .detector_distance (distance_reg),
        .out_valid         (f_valid),
        .out_d             (f_d),
        .out_x             (f_x),
        .out_y             (f_y)
    );

    // theta = atan(x/d); magnitude K*l comes out alongside, y rides as sideband
    ptsa_cordic u_cordic_theta (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (f_valid),
        .in_a      (f_d),
        .in_b      (f_x),
        .in_side   (f_y),
        .out_valid (c1_valid),
        .out_mag   (c1_mag),
        .out_z     (c1_theta),
        .out_side  (c1_y)
    );

    ptsa_gain u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (c1_valid),
        .in_mag    (c1_mag),
        .in_y      (c1_y),
        .in_theta  (c1_theta),
        .out_valid (g_valid),
        .out_lp    (g_lp),
        .out_y     (g_y),
        .out_theta (g_theta)
    );

    // alpha = atan(y/l); theta rides as sideband
    ptsa_cordic u_cordic_alpha (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (g_valid),
        .in_a      (g_lp),
        .in_b      (g_y),
        .in_side   (DW'(g_theta)),
        .out_valid (c2_valid),
        .out_mag   (c2_mag),
        .out_z     (c2_alpha),
        .out_side  (c2_side)
    );

    assign new_valid            = c2_valid && ce;
    assign new_word.theta_angle = c2_side[ANGLE_W-1:0];
    assign new_word.alpha_angle = c2_alpha;

    // gained magnitude of the second pass is not needed
    logic unused_mag;
    assign unused_mag = ^c2_mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            // output slot frees: drain skid first, else take the new word
            out_valid_reg  <= skid_valid_reg || new_valid;
            skid_valid_reg <= 1'b0;
        end else if (new_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : new_word;
        end else if (new_valid) begin
            skid_word_reg <= new_word;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

/* tb/pixel_to_scattering_angles_chk.sv */
// Checker: watches both word channels, predicts the angles and compares them.
module pixel_to_scattering_angles_chk (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  ptsa_pkg::in_word_t   s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  ptsa_pkg::out_word_t  m_data,
    input  logic                 cfg_we,
    input  ptsa_pkg::reg_index_t cfg_idx,
    input  logic [31:0]          cfg_val,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ptsa_pkg::*;

    localparam longint ATAN_TAB [40] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64,
        32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    logic [19:0] cen_col, cen_row;
    logic [23:0] pitch_w, pitch_h, dist_um;
    out_word_t   angle_q[$];

    // vectoring rotation; >>> on longint floors, matching the datapath
    function automatic longint vector_angle(longint a, longint b, output longint mag);
        longint z, sa, sb;
        int n;
        z = 0;
        n = (CORDIC_STAGES > 40) ? 40 : CORDIC_STAGES;
        for (int i = 0; i < n; i++) begin
            sa = a >>> i;
            sb = b >>> i;
            if (b >= 0) begin
                a = a + sb; b = b - sa; z = z + ATAN_TAB[i];
            end else begin
                a = a - sb; b = b + sa; z = z - ATAN_TAB[i];
            end
        end
        mag = a;
        return z;
    endfunction

    function automatic out_word_t pixel_angles(in_word_t w);
        longint x, y, d, m, kl, lp, dummy, th, al;
        longint unsigned hi, lo;
        out_word_t r;
        x = (longint'(w.col_index) * 256 - longint'(cen_col)) * longint'(pitch_w);
        y = (longint'(w.row_index) * 256 - longint'(cen_row)) * longint'(pitch_h);
        d = ((dist_um == 0) ? 64'sd1 : longint'(dist_um)) * 65536;
        m = d;
        if ((x < 0 ? -x : x) > m) m = (x < 0 ? -x : x);
        if ((y < 0 ? -y : y) > m) m = (y < 0 ? -y : y);
        while (m < (64'sd1 <<< 50)) begin
            x = x * 2; y = y * 2; d = d * 2; m = m * 2;
        end
        th = vector_angle(d, x, kl);
        hi = longint'(kl) >> 20;
        lo = kl & 64'hFFFFF;
        lp = ((hi * 652032874) >> 10) + ((lo * 652032874) >> 30);
        al = vector_angle(lp, y, dummy);
        r.theta_angle = th[31:0];
        r.alpha_angle = al[31:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        out_word_t e;
        int nerr;
        nerr = 0;
        if (!aresetn) begin
            cen_col <= 20'd524288; cen_row <= 20'd524288;
            pitch_w <= 24'd44032; pitch_h <= 24'd44032; dist_um <= 24'd1000000;
            angle_q.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_CENTER_COL:   cen_col <= cfg_val[19:0];
                    REG_CENTER_ROW:   cen_row <= cfg_val[19:0];
                    REG_PIXEL_WIDTH:  pitch_w <= cfg_val[23:0];
                    REG_PIXEL_HEIGHT: pitch_h <= cfg_val[23:0];
                    REG_DET_DISTANCE: dist_um <= cfg_val[23:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) angle_q.push_back(pixel_angles(s_data));
            if (m_valid && m_ready) begin
                if (angle_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, m_data);
                    nerr = nerr + 1;
                end else begin
                    e = angle_q.pop_front();
                    if (e.theta_angle !== m_data.theta_angle) begin
                        $display("%0t: theta mismatch expected %0d actual %0d", $time,
                                 e.theta_angle, m_data.theta_angle);
                        nerr = nerr + 1;
                    end
                    if (e.alpha_angle !== m_data.alpha_angle) begin
                        $display("%0t: alpha mismatch expected %0d actual %0d", $time,
                                 e.alpha_angle, m_data.alpha_angle);
                        nerr = nerr + 1;
                    end
                end
            end
            fail_count <= fail_count + nerr;
            pending <= angle_q.size();
        end
    end
endmodule

/* tb/pixel_to_scattering_angles_tb.sv */
// Testbench top: clock, reset, APB setup, pixel stimulus and verdict.
module pixel_to_scattering_angles_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ptsa_pkg::*;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    in_word_t s_data;
    out_word_t m_data;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata, prdata;
    int fail_count, pending;

    // rx_mode: 0 random stalls, 1 never stall, 2 long hold-off
    int  rx_mode;
    bit  done;
    int  quiet_cycles;

    pixel_to_scattering_angles i_dut (.*);

    // checker sees a register write on the APB access edge
    pixel_to_scattering_angles_chk i_chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_we(psel && penable && pwrite && pready),
        .cfg_idx(reg_index_t'(paddr[4:2])), .cfg_val(pwdata),
        .fail_count, .pending);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // receiver: random stalls, a stall-free stretch, one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else if (rx_mode == 1) m_ready <= 1;
        else if (rx_mode == 2) m_ready <= 0;
        else m_ready <= ($urandom_range(99) >= 15);
    end

    // watchdog: cycles with no accepted word on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000 && !done) begin
            $display("pixel_to_scattering_angles_tb: FAIL");
            $finish;
        end
    end

    task automatic apb_write(reg_index_t idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // drives one pixel word, idling at random when gaps are on
    task automatic send_pixel(logic [11:0] c, logic [11:0] r, bit gaps);
        while (gaps && $urandom_range(99) < 15) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data.col_index <= c;
        s_data.row_index <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (90) @(posedge aclk);
    endtask

    task automatic set_geometry(logic [19:0] cc, logic [19:0] cr, logic [23:0] pw,
                                logic [23:0] ph, logic [23:0] dd);
        apb_write(REG_CENTER_COL, 32'(cc));
        apb_write(REG_CENTER_ROW, 32'(cr));
        apb_write(REG_PIXEL_WIDTH, 32'(pw));
        apb_write(REG_PIXEL_HEIGHT, 32'(ph));
        apb_write(REG_DET_DISTANCE, 32'(dd));
    endtask

    task automatic random_block(int n, bit gaps);
        for (int i = 0; i < n; i++)
            send_pixel(12'($urandom_range(4095)), 12'($urandom_range(4095)), gaps);
    endtask

    initial begin
        aresetn = 0; s_valid = 0; s_data = '0; rx_mode = 0; done = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: corners and centre under reset geometry
        send_pixel(0, 0, 0);
        send_pixel(4095, 4095, 0);
        send_pixel(0, 4095, 0);
        send_pixel(4095, 0, 0);
        send_pixel(2048, 2048, 0);
        send_pixel(12'hAAA, 12'h555, 0);
        send_pixel(12'h555, 12'hAAA, 0);
        drain();
        // zero distance acts as one, zero pixel height gives alpha near zero, oversized writes masked
        apb_write(REG_DET_DISTANCE, 32'hFF00_0000);
        apb_write(REG_PIXEL_HEIGHT, 32'hFF00_0000);
        send_pixel(0, 0, 0);
        send_pixel(4095, 4095, 0);
        send_pixel(2048, 17, 0);
        drain();
        // extremes: max everything, then min pitch with min distance
        set_geometry(20'hFFFFF, 20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(0, 0, 0);
        send_pixel(4095, 4095, 0);
        send_pixel(0, 4095, 0);
        drain();
        set_geometry(20'd0, 20'd0, 24'd1, 24'd1, 24'd1);
        send_pixel(4095, 4095, 0);
        send_pixel(0, 0, 0);
        send_pixel(1, 4095, 0);
        drain();

        // random geometries, random pixels with gaps
        for (int p = 0; p < 4; p++) begin
            set_geometry(20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)),
                         24'($urandom_range(24'hFFFFFF, 1)),
                         24'($urandom_range(24'hFFFFFF, 1)),
                         24'($urandom_range(24'hFFFFFF, 1)));
            random_block(150, 1);
            drain();
        end
        // realistic geometry, stall-free stretch
        set_geometry(20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)),
                     24'($urandom_range(50000, 20000)), 24'($urandom_range(50000, 20000)),
                     24'($urandom_range(24'hFFFFFF, 100000)));
        rx_mode = 1;
        random_block(200, 0);
        // long hold-off while the sender keeps pushing
        rx_mode = 2;
        fork
            random_block(150, 0);
            begin
                repeat (300) @(posedge aclk);
                rx_mode = 0;
            end
        join
        drain();
        random_block(50, 1);
        drain();

        done = 1;
        if (fail_count == 0)
            $display("pixel_to_scattering_angles_tb: PASS");
        else
            $display("pixel_to_scattering_angles_tb: FAIL");
        $finish;
    end
endmodule
